FILE: sv/trs_pkg.sv
`default_nettype none
package trs_pkg;

   localparam int NumTopicsDefault = 4;
   localparam int DepthDefault = 8;

   localparam logic [1:0] KIND_ENQ = 2'd0;
   localparam logic [1:0] KIND_LOOK = 2'd1;
   localparam logic [1:0] KIND_DEQ = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NONE = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_NOCONT = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_NOTAGED = 3'd5;

   localparam logic [2:0] CSR_AGE = 3'd0;
   localparam logic [2:0] CSR_TOPICS = 3'd1;
   localparam logic [2:0] CSR_CAP0 = 3'd2;
   localparam logic [2:0] CSR_CAP3 = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  topic;
      logic [31:0] last_entry;
      logic [15:0] publisher_id;
      logic [31:0] content_word;
      logic        has_content;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] entry_number;
      logic [15:0] found_publisher;
      logic [31:0] found_content;
      logic [31:0] found_stamp;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture request and topic bookkeeping
      logic tick;      // advance time
      logic enq;       // write slot, bump fill and number
      logic rd;        // issue slot read at scan offset
      logic scan_next; // advance scan offset
      logic pass2;     // restart scan for the larger-number pass
      logic deq;       // pop head
      logic set_rsp;   // load result from status code
      logic rsp_found; // result carries the read slot
      logic [2:0] code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic known;
      logic full;
      logic empty;
      logic has_content;
      logic scan_end;
      logic hit_eq;
      logic hit_gt;
      logic aged;
   } sts_type;

endpackage
`default_nettype wire

FILE: sv/trs_datapath.sv
`default_nettype none
module trs_datapath #(
   parameter int NUM_TOPICS = trs_pkg::NumTopicsDefault,
   parameter int DEPTH = trs_pkg::DepthDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data,
   input  wire trs_pkg::req_type req_payload,
   input  wire trs_pkg::cmd_type cmd,
   output trs_pkg::sts_type      sts,
   output trs_pkg::rsp_type      rsp_payload
);
   import trs_pkg::*;

   localparam int TW = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
   localparam int DW = $clog2(DEPTH);
   localparam int CW = DW + 1;
   localparam int SW = TW + DW;
   localparam int NS = NUM_TOPICS * (1 << DW);

   logic [31:0] age_ff;
   logic [2:0]  topics_ff;
   logic [3:0]  cap_ff [4];
   logic [31:0] next_ff, now_ff;
   logic [DW-1:0] head_ff [NUM_TOPICS];
   logic [CW-1:0] fill_ff [NUM_TOPICS];

   logic [31:0] mem_num [NS];
   logic [15:0] mem_pub [NS];
   logic [31:0] mem_cont [NS];
   logic [31:0] mem_stamp [NS];

   req_type       q_ff;
   logic          known_ff;
   logic [TW-1:0] t_ff;
   logic [DW-1:0] hd_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] k_ff;
   logic [31:0]   want_ff;
   logic [31:0]   r_num_ff, r_stamp_ff, r_cont_ff;
   logic [15:0]   r_pub_ff;
   rsp_type       rsp_ff, rsp_in;

   logic [TW-1:0] t_sel;
   logic          known_c;
   logic [3:0]    cap_c;
   logic [CW:0]   cap_lim;
   logic [DW:0]   pos;
   logic [DW-1:0] off;
   logic [SW-1:0] addr;
   logic [DW:0]   wpos;
   logic [DW-1:0] woff;
   logic [SW-1:0] waddr;
   logic [31:0]   age;

   always_comb begin
      t_sel = TW'(req_payload.topic);
      known_c = ({1'b0, req_payload.topic} < topics_ff)
         && ({30'd0, req_payload.topic} < NUM_TOPICS);
      cap_c = cap_ff[q_ff.topic];
      cap_lim = (32'(cap_c) > DEPTH) ? (CW+1)'(DEPTH) : (CW+1)'(cap_c);
      pos = {1'b0, hd_ff} + k_ff[DW:0];
      off = (pos >= (DW+1)'(DEPTH)) ? DW'(pos - (DW+1)'(DEPTH)) : pos[DW-1:0];
      addr = {t_ff, off};
      wpos = {1'b0, hd_ff} + n_ff[DW:0];
      woff = (wpos >= (DW+1)'(DEPTH)) ? DW'(wpos - (DW+1)'(DEPTH)) : wpos[DW-1:0];
      waddr = {t_ff, woff};
      age = now_ff - r_stamp_ff;
      sts.known = known_ff;
      sts.full = {1'b0, n_ff} >= cap_lim;
      sts.empty = (n_ff == '0);
      sts.has_content = q_ff.has_content;
      sts.scan_end = (k_ff == n_ff);
      sts.hit_eq = (r_num_ff == want_ff);
      sts.hit_gt = (r_num_ff > want_ff);
      sts.aged = (age > age_ff);
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.set_rsp) begin
         rsp_in = '0;
         rsp_in.status = cmd.code;
         if (cmd.enq) rsp_in.entry_number = next_ff;
         if (cmd.rsp_found) begin
            rsp_in.entry_number = r_num_ff;
            rsp_in.found_publisher = r_pub_ff;
            rsp_in.found_content = r_cont_ff;
            rsp_in.found_stamp = r_stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= '0;
         topics_ff <= '0;
         for (int i = 0; i < 4; i++) cap_ff[i] <= 4'd8;
         next_ff <= 32'd1;
         now_ff <= '0;
         for (int i = 0; i < NUM_TOPICS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index) inside
               CSR_AGE: age_ff <= csr_data;
               CSR_TOPICS: topics_ff <= csr_data[2:0];
               [CSR_CAP0:CSR_CAP3]: cap_ff[2'(csr_index - CSR_CAP0)] <= csr_data[3:0];
               default: ;
            endcase
         end
         if (cmd.tick) now_ff <= now_ff + 32'd1;
         if (cmd.enq) begin
            fill_ff[t_ff] <= n_ff + CW'(1);
            next_ff <= next_ff + 32'd1;
         end
         if (cmd.deq) begin
            head_ff[t_ff] <= (hd_ff == DW'(DEPTH - 1)) ? '0 : hd_ff + DW'(1);
            fill_ff[t_ff] <= n_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff <= req_payload;
         known_ff <= known_c;
         t_ff <= t_sel;
         hd_ff <= head_ff[t_sel];
         n_ff <= fill_ff[t_sel];
         k_ff <= '0;
         want_ff <= req_payload.last_entry + 32'd1;
      end else if (cmd.pass2) begin
         k_ff <= '0;
      end else if (cmd.scan_next) begin
         k_ff <= k_ff + CW'(1);
      end
      if (cmd.enq) begin
         mem_num[waddr] <= next_ff;
         mem_pub[waddr] <= q_ff.publisher_id;
         mem_cont[waddr] <= q_ff.content_word;
         mem_stamp[waddr] <= now_ff;
      end
      if (cmd.rd) begin
         r_num_ff <= mem_num[addr];
         r_pub_ff <= mem_pub[addr];
         r_cont_ff <= mem_cont[addr];
         r_stamp_ff <= mem_stamp[addr];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/trs_control.sv
`default_nettype none
module trs_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic [1:0]       kind,
   input  wire trs_pkg::sts_type sts,
   output trs_pkg::cmd_type      cmd
);
   import trs_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_DEQ = 3'd4;
   localparam logic [2:0] S_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff;
   logic       pass_ff, pass_in;
   logic       rv_ff, rv_in;

   assign req_stall = reset || (state_ff != S_IDLE) || (rv_ff && rsp_stall);
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      rv_in = rv_ff && rsp_stall;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               if (kind == KIND_TICK) begin
                  cmd.tick = 1'b1;
                  cmd.set_rsp = 1'b1;
                  cmd.code = ST_OK;
                  rv_in = 1'b1;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            cmd.set_rsp = 1'b1;
            state_in = S_IDLE;
            pass_in = 1'b0;
            if (!sts.known) cmd.code = ST_UNKNOWN;
            else if (kind_ff == KIND_ENQ) begin
               if (sts.full) cmd.code = ST_FULL;
               else if (!sts.has_content) cmd.code = ST_NOCONT;
               else begin
                  cmd.code = ST_OK;
                  cmd.enq = 1'b1;
               end
            end else if (sts.empty) cmd.code = ST_NONE;
            else begin
               cmd.set_rsp = 1'b0;
               state_in = S_READ;
            end
            if (cmd.set_rsp) rv_in = 1'b1;
         end
         S_READ: begin
            cmd.rd = 1'b1;
            cmd.scan_next = 1'b1;
            state_in = (kind_ff == KIND_DEQ) ? S_DEQ : S_CHECK;
         end
         S_CHECK: begin
            if (pass_ff ? sts.hit_gt : sts.hit_eq) begin
               cmd.set_rsp = 1'b1;
               cmd.rsp_found = 1'b1;
               cmd.code = ST_OK;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else if (!sts.scan_end) begin
               state_in = S_READ;
            end else if (!pass_ff) begin
               pass_in = 1'b1;
               cmd.pass2 = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.set_rsp = 1'b1;
               cmd.code = ST_NONE;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DEQ: begin
            cmd.set_rsp = 1'b1;
            rv_in = 1'b1;
            state_in = S_IDLE;
            if (sts.aged) begin
               cmd.deq = 1'b1;
               cmd.rsp_found = 1'b1;
               cmd.code = ST_OK;
            end else begin
               cmd.code = ST_NOTAGED;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff <= 1'b0;
         rv_ff <= 1'b0;
         kind_ff <= KIND_TICK;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
         rv_ff <= rv_in;
         if (cmd.load) kind_ff <= kind;
      end
   end

endmodule
`default_nettype wire

FILE: sv/topic_ring_store_unit.sv
`default_nettype none
// Topic ring store: one ring queue per topic in a shared slot memory. Each
// request gives exactly one response. A tick is answered directly from idle;
// enqueue and refusals are answered from the decide state, and dequeue after
// a slot read. A lookup reads slots in the read and check states, up to
// twice the fill of the topic when no equal number is found. The next request
// is taken once the current one has its response registered and that response
// is taken or not stalled.
module topic_ring_store_unit #(
   parameter int NUM_TOPICS = trs_pkg::NumTopicsDefault,
   parameter int DEPTH = trs_pkg::DepthDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire trs_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output trs_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data
);
   import trs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   trs_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(req_payload.kind),
      .sts(sts), .cmd(cmd)
   );

   trs_datapath #(.NUM_TOPICS(NUM_TOPICS), .DEPTH(DEPTH)) u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_payload(req_payload), .cmd(cmd), .sts(sts),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire
